// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/bcgi_pkg.sv =====
package bcgi_pkg;
  localparam int MaxRows = 32;
  localparam int MaxColumns = 128;
  localparam int MaxPoints = 256;
  localparam int RowBits = $clog2(MaxRows);
  localparam int ColBits = $clog2(MaxColumns);
  localparam int PtBits = $clog2(MaxPoints);
  localparam int AddrBits = RowBits + ColBits + PtBits;
  localparam int Depth = MaxRows * MaxColumns * MaxPoints;

  // Configuration register indexes.
  localparam logic [2:0] RegFirstMin = 3'd0;
  localparam logic [2:0] RegFirstStep = 3'd1;
  localparam logic [2:0] RegSecondMin = 3'd2;
  localparam logic [2:0] RegSecondStep = 3'd3;
  localparam logic [2:0] RegFirstCount = 3'd4;
  localparam logic [2:0] RegSecondCount = 3'd5;
  localparam logic [2:0] RegPoints = 3'd6;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef logic [AddrBits-1:0] addr_t;
endpackage

// ===== hdl/bcgi_ram.sv =====
module bcgi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/bilinear_curve_grid_interpolator_core.sv =====
// Bilinear interpolator over a grid of stored curves.
// Input words are taken on start while busy is low. req_type selects a write
// (stores q_value and intensity_value at row, column, point) or a query
// (first_coord, second_coord, point_index). A write gives no result.
// A query gives one result word, marked by done for one cycle,
// with q_out, intensity_out and out_of_range.
// A query runs two 41-step restoring divisions (one per axis, one quotient bit
// per cycle, one after the other in a shared unit), then four reads of the
// single-ported intensity memory, each followed by a multiply and an
// accumulate. busy stays high until the query reaches its finish state and
// drops as done rises; the next word may be taken at the edge that ends
// the done cycle. An out-of-range query ends early: a point index past the
// curve skips both divisions and goes straight to the finish state, and a
// failing axis ends the query at its own check.
// The receiver cannot stall: done is a pulse and the word must be taken.
// Configuration words go through cfg_valid/cfg_ready/cfg_index/cfg_data and
// are taken at any time; write them only while the block is idle.
// Reset restores the configuration registers and the control state; memory
// contents stay undefined until written and need no clearing pass.
`include "assert_macros.svh"
module bilinear_curve_grid_interpolator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [4:0]  row_index,
  input  logic [6:0]  column_index,
  input  logic [7:0]  point_index,
  input  logic signed [31:0] q_value,
  input  logic signed [31:0] intensity_value,
  input  logic signed [23:0] first_coord,
  input  logic signed [23:0] second_coord,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic signed [31:0] q_out,
  output logic signed [31:0] intensity_out,
  output logic        out_of_range
);
  import bcgi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_INIT, S_DIV, S_DIV_DONE, S_RD, S_MUL, S_ACC, S_FIN
  } state_t;

  // Configuration registers.
  logic signed [23:0] first_min, second_min;
  logic [22:0] first_step, second_step;
  logic [5:0]  first_count;
  logic [7:0]  second_count;
  logic [8:0]  points;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_min <= 24'sd62259;
      first_step <= 23'd328;
      second_min <= -24'sd131072;
      second_step <= 23'd3277;
      first_count <= 6'd21;
      second_count <= 8'd121;
      points <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegFirstMin: first_min <= cfg_data[23:0];
        RegFirstStep: first_step <= cfg_data[22:0];
        RegSecondMin: second_min <= cfg_data[23:0];
        RegSecondStep: second_step <= cfg_data[22:0];
        RegFirstCount: first_count <= cfg_data[5:0];
        RegSecondCount: second_count <= cfg_data[7:0];
        RegPoints: points <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Counts limited to the store size.
  logic [8:0] n1, n2, np;
  always_comb begin
    n1 = (first_count > 6'(MaxRows)) ? 9'(MaxRows) : 9'(first_count);
    n2 = (second_count > 8'(MaxColumns)) ? 9'(MaxColumns) : 9'(second_count);
    np = (points > 9'(MaxPoints)) ? 9'(MaxPoints) : points;
  end

  // Memories: q and intensity, one port each.
  logic  mem_we;
  addr_t mem_addr;
  logic [31:0] q_rd, i_rd;

  bcgi_ram #(.Width(32), .Depth(Depth)) u_q_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(q_value), .rdata(q_rd));
  bcgi_ram #(.Width(32), .Depth(Depth)) u_i_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(intensity_value),
    .rdata(i_rd));

  state_t state;
  logic        axis;       // 0 first axis, 1 second axis
  logic [40:0] rem;        // partial remainder
  logic [40:0] num;        // dividend: d << 16, d up to 24 bits
  logic [40:0] quo;
  logic [5:0]  bit_cnt;
  logic [22:0] dstep;
  logic [8:0]  dcount;
  logic [RowBits-1:0] i1;
  logic [ColBits-1:0] i2;
  logic [15:0] w1, w2;
  logic [PtBits-1:0]  pt;
  logic signed [23:0] c2;
  logic [1:0]  corner;
  logic [1:0]  corner_q;
  logic [31:0] q_keep;
  logic [16:0] wa, wb;
  logic [33:0] wprod;      // corner weight, Q0.32 (up to 2^32)
  logic [65:0] acc;

  logic [24:0] diff;
  logic [41:0] trial;

  // Corner address and weight select.
  addr_t rd_addr;
  always_comb begin
    rd_addr = {i1 + RowBits'(corner[1]), i2 + ColBits'(corner[0]), pt};
    wa = corner[1] ? {1'b0, w1} : (17'h10000 - {1'b0, w1});
    wb = corner[0] ? {1'b0, w2} : (17'h10000 - {1'b0, w2});
    mem_we = (state == S_IDLE) && start && (req_type == ReqWrite);
    mem_addr = (state == S_IDLE) ? {row_index, column_index, point_index} : rd_addr;
    trial = {rem, num[40]} - {19'd0, dstep};
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      q_out <= '0;
      intensity_out <= '0;
      out_of_range <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && req_type == ReqQuery) begin
            pt <= point_index;
            c2 <= second_coord;
            axis <= 1'b0;
            dstep <= first_step;
            dcount <= n1;
            diff <= 25'({first_coord[23], first_coord} - {first_min[23], first_min});
            if ({1'b0, point_index} >= np) begin
              state <= S_FIN;
              out_of_range <= 1'b1;
            end else begin
              state <= S_DIV_INIT;
            end
          end
        end
        S_DIV_INIT: begin
          if (diff[24] || dstep == '0 || dcount < 9'd2) begin
            out_of_range <= 1'b1;
            state <= S_FIN;
          end else begin
            num <= {1'b0, diff[23:0], 16'd0};
            rem <= '0;
            quo <= '0;
            bit_cnt <= 6'd41;
            state <= S_DIV;
          end
        end
        // One quotient bit per cycle, restoring.
        S_DIV: begin
          if (!trial[41]) begin
            rem <= trial[40:0];
            quo <= {quo[39:0], 1'b1};
          end else begin
            rem <= {rem[39:0], num[40]};
            quo <= {quo[39:0], 1'b0};
          end
          num <= {num[39:0], 1'b0};
          bit_cnt <= bit_cnt - 6'd1;
          if (bit_cnt == 6'd1) state <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          if (quo[40:16] >= 25'(dcount - 9'd1)) begin
            out_of_range <= 1'b1;
            state <= S_FIN;
          end else if (!axis) begin
            i1 <= quo[16+RowBits-1:16];
            w1 <= quo[15:0];
            axis <= 1'b1;
            dstep <= second_step;
            dcount <= n2;
            diff <= 25'({c2[23], c2} - {second_min[23], second_min});
            state <= S_DIV_INIT;
          end else begin
            i2 <= quo[16+ColBits-1:16];
            w2 <= quo[15:0];
            corner <= 2'd0;
            acc <= '0;
            out_of_range <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: begin
          corner_q <= corner;
          state <= S_MUL;
        end
        S_MUL: begin
          wprod <= {17'd0, wa} * {17'd0, wb};
          if (corner_q == 2'd0) q_keep <= q_rd;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + {32'd0, wprod} * {34'd0, i_rd[31] ^ 1'b1, i_rd[30:0]};
          if (corner == 2'd3) begin
            state <= S_FIN;
          end else begin
            corner <= corner + 2'd1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          done <= 1'b1;
          if (out_of_range) begin
            q_out <= '0;
            intensity_out <= '0;
          end else begin
            q_out <= q_keep;
            if ((acc + 66'h80000000) >> 32 > 66'hFFFFFFFF)
              intensity_out <= 32'h7FFFFFFF;
            else
              intensity_out <= 32'(((acc + 66'h80000000) >> 32) ^ 66'h80000000);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks.
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `ASSERT_IMPLIES(a_idle_done, clk, rst, done, state == S_IDLE)
  `ASSERT_IMPLIES(a_no_write_busy, clk, rst, mem_we, !busy)
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import bcgi_pkg::*;

  // Result word of one query.
  typedef struct {
    logic signed [31:0] q;
    logic signed [31:0] inten;
    logic               oor;
  } grid_result_t;

  // One row of the directed table.
  typedef struct {
    logic               req;
    logic [4:0]         row;
    logic [6:0]         col;
    logic [7:0]         pt;
    logic signed [31:0] q;
    logic signed [31:0] inten;
    logic signed [23:0] c1;
    logic signed [23:0] c2;
    bit                 typed;
    grid_result_t       res;
  } directed_row_t;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 150;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = ReqWrite;
  logic [4:0]         row_index = '0;
  logic [6:0]         column_index = '0;
  logic [7:0]         point_index = '0;
  logic signed [31:0] q_value = '0;
  logic signed [31:0] intensity_value = '0;
  logic signed [23:0] first_coord = '0;
  logic signed [23:0] second_coord = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = RegFirstMin;
  logic [31:0]        cfg_data = '0;
  logic               done;
  logic signed [31:0] q_out;
  logic signed [31:0] intensity_out;
  logic               out_of_range;

  bilinear_curve_grid_interpolator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .row_index(row_index), .column_index(column_index),
    .point_index(point_index), .q_value(q_value), .intensity_value(intensity_value),
    .first_coord(first_coord), .second_coord(second_coord),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .q_out(q_out),
    .intensity_out(intensity_out), .out_of_range(out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the configuration registers.
  longint      first_min;
  int unsigned first_step;
  longint      second_min;
  int unsigned second_step;
  int unsigned first_count;
  int unsigned second_count;
  int unsigned curve_points;

  // Shadow of the curve stores; only written entries exist.
  logic [31:0] q_mem[int];
  logic [31:0] inten_mem[int];
  bit          planned_writes[int];

  grid_result_t pending_results[$];
  int          failures = 0;
  int          queries_sent = 0;
  int          writes_sent = 0;
  int          results_seen = 0;
  int          oor_seen = 0;
  int          sender_idle_pct = 0;
  longint      cycles = 0;

  function automatic int grid_addr(int unsigned r, int unsigned c, int unsigned p);
    return (r * MaxColumns + c) * MaxPoints + p;
  endfunction

  function automatic int unsigned clamp_count(int unsigned v, int unsigned mx);
    return (v > mx) ? mx : v;
  endfunction

  // Finds the cell and the Q0.16 weight along one axis; zero when outside.
  function automatic bit find_cell(longint c, longint mn, int unsigned step,
                                   int unsigned cnt, output int unsigned cell_idx,
                                   output int unsigned w);
    longint d;
    longint unsigned i;
    longint unsigned r;
    cell_idx = 0;
    w = 0;
    d = c - mn;
    if (step == 0 || cnt < 2 || d < 0) return 1'b0;
    i = longint'(d) / step;
    if (i >= cnt - 1) return 1'b0;
    r = d - i * step;
    cell_idx = i;
    w = (r << 16) / step;
    return 1'b1;
  endfunction

  // Locates a query on the grid; gives the two cells and weights.
  function automatic bit locate_query(logic [7:0] pt, logic signed [23:0] c1,
                                      logic signed [23:0] c2,
                                      output int unsigned i1, output int unsigned w1,
                                      output int unsigned i2, output int unsigned w2);
    bit ok;
    i1 = 0; w1 = 0; i2 = 0; w2 = 0;
    ok = pt < clamp_count(curve_points, MaxPoints);
    if (ok) ok = find_cell(c1, first_min, first_step,
                           clamp_count(first_count, MaxRows), i1, w1);
    if (ok) ok = find_cell(c2, second_min, second_step,
                           clamp_count(second_count, MaxColumns), i2, w2);
    return ok;
  endfunction

  // Blends the four corner intensities with the bilinear weights.
  function automatic grid_result_t blend_query(logic [7:0] pt, logic signed [23:0] c1,
                                               logic signed [23:0] c2);
    grid_result_t res;
    int unsigned i1, w1, i2, w2;
    bit [63:0] a1, b1, a2, b2, u00, u01, u10, u11, acc, rnd;
    res.q = '0;
    res.inten = '0;
    res.oor = 1'b1;
    if (!locate_query(pt, c1, c2, i1, w1, i2, w2)) return res;
    a1 = 65536 - w1; b1 = w1;
    a2 = 65536 - w2; b2 = w2;
    u00 = {32'd0, inten_mem[grid_addr(i1, i2, pt)] ^ 32'h8000_0000};
    u01 = {32'd0, inten_mem[grid_addr(i1, i2 + 1, pt)] ^ 32'h8000_0000};
    u10 = {32'd0, inten_mem[grid_addr(i1 + 1, i2, pt)] ^ 32'h8000_0000};
    u11 = {32'd0, inten_mem[grid_addr(i1 + 1, i2 + 1, pt)] ^ 32'h8000_0000};
    acc = a1 * a2 * u00 + a1 * b2 * u01 + b1 * a2 * u10 + b1 * b2 * u11;
    rnd = (acc + 64'h8000_0000) >> 32;
    if (rnd > 64'hFFFF_FFFF) rnd = 64'hFFFF_FFFF;
    res.q = q_mem[grid_addr(i1, i2, pt)];
    res.inten = rnd[31:0] ^ 32'h8000_0000;
    res.oor = 1'b0;
    return res;
  endfunction

  // Drives one word, waits until it is taken, then updates the shadow state.
  task automatic send_word(directed_row_t w);
    start <= 1'b1;
    req_type <= w.req;
    row_index <= w.row;
    column_index <= w.col;
    point_index <= w.pt;
    q_value <= w.q;
    intensity_value <= w.inten;
    first_coord <= w.c1;
    second_coord <= w.c2;
    do @(posedge clk); while (busy);
    if (w.req == ReqWrite) begin
      q_mem[grid_addr(w.row, w.col, w.pt)] = w.q;
      inten_mem[grid_addr(w.row, w.col, w.pt)] = w.inten;
      writes_sent++;
    end else begin
      pending_results.push_back(w.typed ? w.res : blend_query(w.pt, w.c1, w.c2));
      queries_sent++;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic directed_row_t make_write(logic [4:0] r, logic [6:0] c, logic [7:0] p,
                                               logic [31:0] q, logic [31:0] i);
    directed_row_t w;
    w = '{ReqWrite, r, c, p, q, i, $urandom, $urandom, 1'b0, '{0, 0, 1'b0}};
    planned_writes[grid_addr(r, c, p)] = 1'b1;
    return w;
  endfunction

  function automatic directed_row_t make_query(logic [7:0] p, logic signed [23:0] c1,
                                               logic signed [23:0] c2);
    directed_row_t w;
    w = '{ReqQuery, $urandom, $urandom, p, $urandom, $urandom, c1, c2, 1'b0,
          '{0, 0, 1'b0}};
    return w;
  endfunction

  // Sends a query, first loading any corner that was never written.
  task automatic send_query(logic [7:0] p, logic signed [23:0] c1, logic signed [23:0] c2);
    int unsigned i1, w1, i2, w2;
    int unsigned r, c;
    if (locate_query(p, c1, c2, i1, w1, i2, w2)) begin
      for (int k = 0; k < 4; k++) begin
        r = i1 + k / 2;
        c = i2 + k % 2;
        if (!planned_writes.exists(grid_addr(r, c, p)))
          send_word(make_write(r, c, p, $urandom, $urandom));
      end
    end
    send_word(make_query(p, c1, c2));
  endtask

  // Picks a coordinate inside the grid along one axis when the grid allows it.
  function automatic logic signed [23:0] pick_coord(longint mn, int unsigned step,
                                                    int unsigned cnt);
    longint v;
    if (step == 0 || cnt < 2) return $urandom;
    v = mn + longint'($urandom_range(cnt - 2)) * step + ($urandom % step);
    if (v > 8388607 || v < -8388608) return $urandom;
    return v;
  endfunction

  // Drives one register word; the caller lowers cfg_valid after the last one.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegFirstMin: first_min = longint'($signed(data[23:0]));
      RegFirstStep: first_step = data[22:0];
      RegSecondMin: second_min = longint'($signed(data[23:0]));
      RegSecondStep: second_step = data[22:0];
      RegFirstCount: first_count = data[5:0];
      RegSecondCount: second_count = data[7:0];
      RegPoints: curve_points = data[8:0];
      default: ;
    endcase
  endtask

  // Lets the block drain before any register write.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_config(int a0, int a1, int a2, int a3, int a4, int a5, int a6);
    wait_idle();
    write_reg(RegFirstMin, a0);
    write_reg(RegFirstStep, a1);
    write_reg(RegSecondMin, a2);
    write_reg(RegSecondStep, a3);
    write_reg(RegFirstCount, a4);
    write_reg(RegSecondCount, a5);
    write_reg(RegPoints, a6);
    cfg_valid <= 1'b0;
  endtask

  // One phase of random words: mostly queries inside the grid, some noise.
  task automatic random_phase(int n_items, int idle_pct);
    int unsigned np;
    int          sel;
    logic [7:0]  p;
    sender_idle_pct = idle_pct;
    np = clamp_count(curve_points, MaxPoints);
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      sel = $urandom_range(99);
      p = (np > 0 && sel < 85) ? 8'($urandom_range(np - 1)) : 8'($urandom);
      if (sel < 30) begin
        send_word(make_write($urandom, $urandom, $urandom, $urandom, $urandom));
      end else if (sel < 85) begin
        send_query(p, pick_coord(first_min, first_step, clamp_count(first_count, MaxRows)),
                   pick_coord(second_min, second_step,
                              clamp_count(second_count, MaxColumns)));
      end else begin
        send_query(p, $urandom, $urandom);
      end
    end
  endtask

  // Result checker: every done word is compared with the oldest expectation.
  always @(posedge clk) begin
    grid_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (out_of_range) oor_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected: q=%h i=%h oor=%b",
                 $time, q_out, intensity_out, out_of_range);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (q_out !== e.q) begin
          $display("%0t: q_out expected %h actual %h", $time, e.q, q_out);
          failures++;
        end
        if (intensity_out !== e.inten) begin
          $display("%0t: intensity_out expected %h actual %h", $time, e.inten,
                   intensity_out);
          failures++;
        end
        if (out_of_range !== e.oor) begin
          $display("%0t: out_of_range expected %b actual %b", $time, e.oor,
                   out_of_range);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    directed_row_t dir_rows[$];
    grid_result_t  flagged;
    flagged = '{32'sd0, 32'sd0, 1'b1};
    first_min = 62259;
    first_step = 328;
    second_min = -131072;
    second_step = 3277;
    first_count = 21;
    second_count = 121;
    curve_points = 256;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset grid: extremes and the flagged cases.
    dir_rows.push_back(make_write(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    dir_rows.push_back(make_write(0, 1, 0, 32'h8000_0000, 32'h8000_0000));
    dir_rows.push_back(make_write(1, 0, 0, 32'h0001_0000, 32'h7FFF_FFFF));
    dir_rows.push_back(make_write(1, 1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    dir_rows.push_back(make_query(0, 62259, -131072));
    dir_rows.push_back(make_query(0, 62259 + 164, -131072 + 1638));
    dir_rows.push_back(make_query(0, 62259 + 327, -131072 + 3276));
    dir_rows.push_back(make_write(31, 127, 255, 32'h0000_0000, 32'hFFFF_FFFF));
    dir_rows.push_back(make_write(19, 119, 255, 32'h1234_5678, 32'h7FFF_FFFF));
    dir_rows.push_back(make_write(19, 120, 255, 32'h0, 32'h7FFF_FFFF));
    dir_rows.push_back(make_write(20, 119, 255, 32'h0, 32'h7FFF_FFFF));
    dir_rows.push_back(make_write(20, 120, 255, 32'h0, 32'h7FFF_FFFF));
    dir_rows.push_back(make_query(255, 68808, 262167));
    foreach (dir_rows[k]) send_word(dir_rows[k]);
    dir_rows.delete();
    // Below the minimum, past the last sample, and at the coordinate extremes.
    dir_rows.push_back(make_query(0, 62258, -131072));
    dir_rows.push_back(make_query(0, 68819, -131072));
    dir_rows.push_back(make_query(0, 8388607, 8388607));
    dir_rows.push_back(make_query(0, 62259, -8388608));
    dir_rows.push_back(make_query(0, -8388608, -131072));
    foreach (dir_rows[k]) begin
      dir_rows[k].typed = 1'b1;
      dir_rows[k].res = flagged;
      send_word(dir_rows[k]);
    end

    // Random phases over several register settings.
    random_phase(100, 0);
    load_config(-8388608, 8388607, -100000, 1, 63, 2, 511);
    random_phase(60, 76);
    load_config(0, 65536, 0, 65536, 1, 0, 256);
    random_phase(20, 6);
    load_config(-65536, 4096, -300000, 0, 32, 255, 0);
    random_phase(20, 0);
    load_config(-65536, 4096, -300000, 2000, 32, 128, 1);
    random_phase(100, 76);
    load_config(100, 8388607, 8388607, 8388607, 2, 2, 256);
    random_phase(30, 6);
    load_config(-20000, 1000, 5000, 700, 12, 40, 9);
    random_phase(100, 0);
    load_config(62259, 328, -131072, 3277, 21, 121, 256);
    random_phase(80, 76);

    wait_idle();
    $display("Sent %0d writes and %0d queries over eight register settings.",
             writes_sent, queries_sent);
    $display("Checked %0d result words, %0d of them flagged out of range.",
             results_seen, oor_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
